>>> hdl/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg: shared types and constants of the mutex ownership table
// Command and status codes, the request and response records, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mot_pkg;

  localparam int CMD_W            = 2;
  localparam int HANDLE_W         = 4;
  localparam int TASK_W           = 8;
  localparam int STATUS_W         = 3;
  localparam int HANDLE_SPACE     = 1 << HANDLE_W;

  localparam int NUM_SLOTS_DEF    = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ENTER   = 2'd1,
    CMD_EXIT    = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_WAIT    = 3'd1,
    ST_NOTIFY  = 3'd2,
    ST_KILL    = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5,
    ST_BUSY    = 3'd6
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [TASK_W-1:0]   task_id;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] new_handle;
  } resp_t;

endpackage

`default_nettype wire

>>> hdl/mutex_ownership_table.sv
// ----------------------------------------------------------------------------
// mutex_ownership_table: hardware mutex slot table
// Create, enter, exit and destroy commands on a table of owned mutex slots.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | into      | in_valid, in_stall, in_command, in_handle, in_task_id
//  out     | out of    | out_valid, out_stall, out_status, out_new_handle
//
//  One item per cycle while the output is not stalled; an accepted item enters
//  the input register, and the result register loads from it when not held.
//  The table update lands with the result, so the next item sees it.
//  Reset clears all allocated bits directly; no clearing pass.
//  A stalled result holds its register; one further item waits in the input
//  register, after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module mutex_ownership_table #(
  parameter int NUM_SLOTS    = mot_pkg::NUM_SLOTS_DEF,
  parameter int TASK_ID_BITS = mot_pkg::TASK_ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mot_pkg::CMD_W-1:0]       in_command,
  input  logic [mot_pkg::HANDLE_W-1:0]    in_handle,
  input  logic [mot_pkg::TASK_W-1:0]      in_task_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mot_pkg::STATUS_W-1:0]    out_status,
  output logic [mot_pkg::HANDLE_W-1:0]    out_new_handle
);
  import mot_pkg::*;

  logic    s1_valid_r;
  req_t    s1_req_r;
  logic    out_valid_r;
  resp_t   out_resp_r;
  resp_t   resp;
  logic    out_hold;
  logic    commit;
  logic    accept;

  assign out_hold = out_valid_r && out_stall;
  assign in_stall = s1_valid_r && out_hold;
  assign accept   = in_valid && !in_stall;
  assign commit   = s1_valid_r && !out_hold;

  mot_slot_table #(
    .NUM_SLOTS    (NUM_SLOTS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_slot_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .req    (s1_req_r),
    .resp   (resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (!out_hold) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= '{cmd: cmd_t'(in_command), handle: in_handle, task_id: in_task_id};
    end
    if (commit) begin
      out_resp_r <= resp;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_resp_r.status;
  assign out_new_handle = out_resp_r.new_handle;

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("decided item produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> hdl/mot_find_free.sv
// ----------------------------------------------------------------------------
// mot_find_free: lowest free slot search
// Priority encoder over the allocated bits; reports the lowest clear bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_find_free #(
  parameter int N     = 16,
  parameter int IDX_W = 4
) (
  input  logic [N-1:0]     alloc,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  // scan from the top so the lowest free slot wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!alloc[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mot_slot_table.sv
// ----------------------------------------------------------------------------
// mot_slot_table: slot state and command decision
// Holds allocated bits and owners, decides one command and commits its update.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_slot_table #(
  parameter int NUM_SLOTS    = mot_pkg::NUM_SLOTS_DEF,
  parameter int TASK_ID_BITS = mot_pkg::TASK_ID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  mot_pkg::req_t req,
  output mot_pkg::resp_t resp
);
  import mot_pkg::*;

  // only slots a handle can name are kept
  localparam int ADDR_SLOTS = (NUM_SLOTS < HANDLE_SPACE) ? NUM_SLOTS : HANDLE_SPACE;
  localparam int IDX_W      = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;

  logic [ADDR_SLOTS-1:0]   alloc_r;
  logic [ADDR_SLOTS-1:0]   alloc_nxt;
  logic [TASK_ID_BITS-1:0] owner_r [ADDR_SLOTS];
  logic [TASK_ID_BITS-1:0] owner_nxt;
  logic                    owner_we;
  logic [IDX_W-1:0]        wr_idx;

  logic [TASK_W+TASK_ID_BITS-1:0] caller_ext;
  logic [TASK_ID_BITS-1:0]        caller;
  logic [TASK_ID_BITS-1:0]        cur_owner;
  logic                           in_range;
  logic                           handle_ok;
  logic [IDX_W-1:0]               idx;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;

  mot_find_free #(
    .N     (ADDR_SLOTS),
    .IDX_W (IDX_W)
  ) u_find_free (
    .alloc (alloc_r),
    .found (free_found),
    .idx   (free_idx)
  );

  assign caller_ext = {{TASK_ID_BITS{1'b0}}, req.task_id};
  assign caller     = caller_ext[TASK_ID_BITS-1:0];
  assign in_range   = (int'(req.handle) < NUM_SLOTS);
  assign idx        = req.handle[IDX_W-1:0];
  assign handle_ok  = in_range && alloc_r[idx];
  assign cur_owner  = owner_r[idx];

  always_comb begin
    resp.status     = ST_OK;
    resp.new_handle = '0;
    alloc_nxt       = alloc_r;
    owner_we        = 1'b0;
    owner_nxt       = '0;
    wr_idx          = idx;
    case (req.cmd)
      CMD_CREATE: begin
        if (free_found) begin
          alloc_nxt[free_idx] = 1'b1;
          owner_we            = 1'b1;
          wr_idx              = free_idx;
          resp.new_handle     = HANDLE_W'(free_idx);
        end else begin
          resp.status = ST_FULL;
        end
      end
      CMD_DESTROY: begin
        if (!handle_ok) begin
          resp.status = ST_INVALID;
        end else if (cur_owner == '0) begin
          alloc_nxt[idx] = 1'b0;
        end else begin
          resp.status = ST_BUSY;
        end
      end
      CMD_ENTER: begin
        if (!handle_ok || caller == '0) begin
          resp.status = ST_INVALID;
        end else if (cur_owner == '0) begin
          owner_we  = 1'b1;
          owner_nxt = caller;
        end else if (cur_owner != caller) begin
          resp.status = ST_WAIT;
        end
      end
      CMD_EXIT: begin
        if (!handle_ok || caller == '0) begin
          resp.status = ST_INVALID;
        end else if (cur_owner == caller) begin
          owner_we    = 1'b1;
          resp.status = ST_NOTIFY;
        end else begin
          resp.status = ST_KILL;
        end
      end
      default: begin
        resp.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
    end else if (commit) begin
      alloc_r <= alloc_nxt;
    end
  end

  // owners are only read for allocated slots, and create clears them
  always_ff @(posedge clk) begin
    if (commit && owner_we) begin
      owner_r[wr_idx] <= owner_nxt;
    end
  end

  a_full_means_all_taken: assert property (@(posedge clk) disable iff (!rst_n)
    commit && req.cmd == CMD_CREATE && resp.status == ST_FULL |-> &alloc_r)
    else $error("create reported full with a free slot");

  a_create_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    commit && req.cmd == CMD_CREATE && resp.status == ST_OK |=> alloc_r[$past(free_idx)])
    else $error("created slot not marked allocated");

  a_notify_frees_owner: assert property (@(posedge clk) disable iff (!rst_n)
    commit && resp.status == ST_NOTIFY |=> owner_r[$past(idx)] == '0)
    else $error("released mutex still owned");

  a_busy_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
    commit && resp.status == ST_BUSY |=> alloc_r == $past(alloc_r))
    else $error("busy destroy changed the table");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the mutex ownership table
// Drives create, enter, exit and destroy items with random gaps. A scoreboard
// model of the slot table predicts each response. A monitor stalls at random
// and compares every response field with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

  import mot_pkg::*;

  localparam int NUM_SLOTS     = NUM_SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 400000;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command     = '0;
  logic [HANDLE_W-1:0] in_handle      = '0;
  logic [TASK_W-1:0]   in_task_id     = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_new_handle;

  // Scoreboard copy of the slot table
  logic              slot_taken [NUM_SLOTS];
  logic [TASK_W-1:0] slot_holder[NUM_SLOTS];

  req_t  pending_cmds[$];
  resp_t awaited_responses[$];

  int    error_count    = 0;
  int    cmds_accepted  = 0;
  int    resps_checked  = 0;
  int    cycle_count    = 0;
  int    status_seen[7];
  int    send_gap       = 0;
  int    stall_left     = 0;
  bit    send_no_idle   = 1'b0;
  bit    recv_no_idle   = 1'b0;

  always #4 clk = ~clk;

  mutex_ownership_table DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_handle      (in_handle),
    .in_task_id     (in_task_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_new_handle (out_new_handle)
  );

  // Apply one command to the scoreboard table and return the response.
  function automatic resp_t table_apply(input req_t r);
    resp_t res;
    bit    found;
    int    h;
    res.status     = ST_OK;
    res.new_handle = '0;
    found          = 1'b0;
    h              = int'(r.handle);
    if (r.cmd == CMD_CREATE) begin
      res.status = ST_FULL;
      for (int i = 0; i < NUM_SLOTS && i < HANDLE_SPACE; i++) begin
        if (!found && !slot_taken[i]) begin
          found          = 1'b1;
          slot_taken[i]  = 1'b1;
          slot_holder[i] = '0;
          res.new_handle = HANDLE_W'(i);
          res.status     = ST_OK;
        end
      end
    end else if (h >= NUM_SLOTS || !slot_taken[h]) begin
      res.status = ST_INVALID;
    end else if (r.cmd == CMD_DESTROY) begin
      // any caller may destroy, provided nobody holds it
      if (slot_holder[h] == '0) begin
        slot_taken[h] = 1'b0;
      end else begin
        res.status = ST_BUSY;
      end
    end else if (r.task_id == '0) begin
      res.status = ST_INVALID;
    end else if (r.cmd == CMD_ENTER) begin
      if (slot_holder[h] == '0) begin
        slot_holder[h] = r.task_id;
      end else if (slot_holder[h] != r.task_id) begin
        res.status = ST_WAIT;
      end
    end else begin
      if (slot_holder[h] == r.task_id) begin
        slot_holder[h] = '0;
        res.status     = ST_NOTIFY;
      end else begin
        res.status = ST_KILL;
      end
    end
    return res;
  endfunction

  task automatic push_cmd(input cmd_t c, input int h, input int t);
    req_t r;
    r.cmd     = c;
    r.handle  = HANDLE_W'(h);
    r.task_id = TASK_W'(t);
    pending_cmds.push_back(r);
  endtask

  // Driver: predict on acceptance, then load the next item after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_responses.push_back(table_apply({cmd_t'(in_command), in_handle, in_task_id}));
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_command <= pending_cmds[0].cmd;
          in_handle  <= pending_cmds[0].handle;
          in_task_id <= pending_cmds[0].task_id;
          void'(pending_cmds.pop_front());
          in_valid   <= 1'b1;
          if ($urandom_range(0, 99) < 3) send_no_idle = ~send_no_idle;
          send_gap = send_no_idle ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted response, then draw the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      resps_checked++;
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d handle %0d",
                 $time, out_status, out_new_handle);
        error_count++;
      end else begin
        if (out_status !== awaited_responses[0].status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, awaited_responses[0].status, out_status);
          error_count++;
        end
        if (out_new_handle !== awaited_responses[0].new_handle) begin
          $display("%0t: new_handle mismatch, expected %0d actual %0d",
                   $time, awaited_responses[0].new_handle, out_new_handle);
          error_count++;
        end
        if (out_status < 7) status_seen[out_status]++;
        void'(awaited_responses.pop_front());
      end
      if ($urandom_range(0, 99) < 3) recv_no_idle = ~recv_no_idle;
      stall_left = recv_no_idle ? 0 : $urandom_range(0, 19);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time,
               awaited_responses.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int p_create;
    int p_destroy;
    int roll;
    int h;
    int owner;
    int rival;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_taken[i]  = 1'b0;
      slot_holder[i] = '0;
    end
    for (int i = 0; i < 7; i++) status_seen[i] = 0;

    // Directed: lock life cycle, bad handles, zero caller, extreme ids
    push_cmd(CMD_ENTER, 0, 1);        // nothing allocated yet
    push_cmd(CMD_CREATE, 0, 0);
    push_cmd(CMD_CREATE, 15, 255);
    push_cmd(CMD_CREATE, 9, 7);
    push_cmd(CMD_ENTER, 0, 255);
    push_cmd(CMD_ENTER, 0, 255);      // owner again, no nesting
    push_cmd(CMD_ENTER, 0, 1);        // held by another
    push_cmd(CMD_EXIT, 0, 1);         // not the owner
    push_cmd(CMD_DESTROY, 0, 1);      // still locked
    push_cmd(CMD_EXIT, 0, 255);
    push_cmd(CMD_DESTROY, 0, 3);      // caller does not matter
    push_cmd(CMD_ENTER, 0, 255);      // slot gone
    push_cmd(CMD_EXIT, 15, 2);
    push_cmd(CMD_DESTROY, 15, 2);
    push_cmd(CMD_ENTER, 1, 0);        // zero caller
    push_cmd(CMD_EXIT, 1, 0);
    push_cmd(CMD_DESTROY, 1, 0);
    push_cmd(CMD_CREATE, 6, 128);     // lowest free slot comes back
    push_cmd(CMD_ENTER, 2, 170);
    push_cmd(CMD_EXIT, 2, 85);
    push_cmd(CMD_EXIT, 2, 170);
    push_cmd(CMD_DESTROY, 2, 170);

    // Random: phases that fill, churn or drain the table
    while (pending_cmds.size() < RANDOM_ITEMS + 22) begin
      case ($urandom_range(0, 2))
        0:       begin p_create = 45; p_destroy = 5;  end
        1:       begin p_create = 10; p_destroy = 10; end
        default: begin p_create = 3;  p_destroy = 40; end
      endcase
      repeat (40) begin
        roll  = $urandom_range(0, 99);
        h     = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 15);
        owner = $urandom_range(1, 4);
        rival = (owner % 4) + 1;
        if (roll < p_create) begin
          push_cmd(CMD_CREATE, $urandom_range(0, 15), $urandom_range(0, 255));
        end else if (roll < p_create + p_destroy) begin
          push_cmd(CMD_DESTROY, h, $urandom_range(0, 255));
        end else if ($urandom_range(0, 99) < 70) begin
          // well-formed critical section, sometimes contended
          push_cmd(CMD_ENTER, h, owner);
          if ($urandom_range(0, 99) < 40) push_cmd(CMD_ENTER, h, rival);
          if ($urandom_range(0, 99) < 20) push_cmd(CMD_EXIT, h, rival);
          if ($urandom_range(0, 99) < 30) push_cmd(CMD_ENTER, h, owner);
          if ($urandom_range(0, 99) < 20) push_cmd(CMD_DESTROY, h, rival);
          if ($urandom_range(0, 99) < 85) push_cmd(CMD_EXIT, h, owner);
        end else begin
          push_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                   $urandom_range(0, 255));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid || awaited_responses.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (awaited_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, awaited_responses.size());
      error_count++;
    end

    $display("Sent %0d commands, checked %0d responses, %0d errors", cmds_accepted,
             resps_checked, error_count);
    $display("Status mix: ok %0d wait %0d notify %0d kill %0d invalid %0d full %0d busy %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
